// File: rtl/csvlp_pkg.sv
// Shared types and constants for the CSV line field parser.
// Used by csvlp_parser and csv_line_field_parser_top; no dependencies.
`timescale 1ns / 1ps

package csvlp_pkg;

   localparam int MAX_FIELDS = 256;
   localparam logic [7:0] FIELD_CAP =
      ((MAX_FIELDS - 1) < 255) ? 8'(MAX_FIELDS - 1) : 8'd255;

   localparam logic [7:0] QUOTE_CHAR = 8'h22;
   localparam logic [7:0] COMMA_CHAR = 8'h2C;

   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_END  = 1'b1;

   typedef enum logic [2:0] {
      MODE_START  = 3'd0,
      MODE_PLAIN  = 3'd1,
      MODE_QUOTED = 3'd2,
      MODE_QSEEN  = 3'd3,
      MODE_AFTER  = 3'd4
   } parse_mode_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] char_out;
      logic [7:0] field_number;
      logic       last_field;
      logic       last_of_item;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } step_type;

endpackage

// File: rtl/csvlp_parser.sv
// Per-byte parse state machine: holds mode, line and field state, and forms
// up to two result beats for the item presented. Depends on csvlp_pkg.
`timescale 1ns / 1ps

module csvlp_parser import csvlp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  logic [7:0] char_in,
   input  logic       char_valid,
   input  logic       line_end,
   output step_type   step
);

   parse_mode_type mode_ff, mode_in;
   logic           has_chars_ff, has_chars_in;
   logic [7:0]     field_ff, field_in;

   logic           char_emit;
   logic           char_is_end;
   logic [7:0]     char_value;
   logic           next_field;
   logic           end_emit;
   logic [7:0]     field_mid;
   result_type     char_res;
   result_type     end_res;

   // next state
   always_comb begin
      mode_in    = mode_ff;
      next_field = 1'b0;
      if (char_valid) begin
         case (mode_ff)
            MODE_PLAIN, MODE_AFTER: begin
               if (char_in == COMMA_CHAR) begin
                  next_field = 1'b1;
                  mode_in    = MODE_START;
               end
            end
            MODE_QUOTED: begin
               if (char_in == QUOTE_CHAR) begin
                  mode_in = MODE_QSEEN;
               end
            end
            MODE_QSEEN: begin
               if (char_in == QUOTE_CHAR) begin
                  mode_in = MODE_QUOTED;
               end else if (char_in == COMMA_CHAR) begin
                  next_field = 1'b1;
                  mode_in    = MODE_START;
               end else begin
                  mode_in = MODE_AFTER;
               end
            end
            default: begin
               if (char_in == QUOTE_CHAR) begin
                  mode_in = MODE_QUOTED;
               end else if (char_in == COMMA_CHAR) begin
                  next_field = 1'b1;
                  mode_in    = MODE_START;
               end else begin
                  mode_in = MODE_PLAIN;
               end
            end
         endcase
      end
      field_mid = (next_field && (field_ff < FIELD_CAP)) ? field_ff + 8'd1 : field_ff;
      has_chars_in = has_chars_ff | char_valid;
      field_in     = field_mid;
      if (line_end) begin
         mode_in      = MODE_START;
         has_chars_in = 1'b0;
         field_in     = 8'd0;
      end
   end

   // outputs
   always_comb begin
      char_emit   = 1'b0;
      char_is_end = 1'b0;
      char_value  = char_in;
      if (char_valid) begin
         case (mode_ff)
            MODE_PLAIN, MODE_AFTER: begin
               char_emit   = 1'b1;
               char_is_end = (char_in == COMMA_CHAR);
            end
            MODE_QUOTED: begin
               char_emit = (char_in != QUOTE_CHAR);
            end
            MODE_QSEEN: begin
               char_emit   = 1'b1;
               char_is_end = (char_in == COMMA_CHAR);
            end
            default: begin
               char_emit   = (char_in != QUOTE_CHAR);
               char_is_end = (char_in == COMMA_CHAR);
            end
         endcase
      end
      end_emit = line_end && (has_chars_ff || char_valid);

      char_res.kind         = char_is_end ? KIND_END : KIND_CHAR;
      char_res.char_out     = char_is_end ? 8'd0 : char_value;
      char_res.field_number = field_ff;
      char_res.last_field   = 1'b0;
      char_res.last_of_item = ~end_emit;

      end_res.kind         = KIND_END;
      end_res.char_out     = 8'd0;
      end_res.field_number = field_mid;
      end_res.last_field   = 1'b1;
      end_res.last_of_item = 1'b1;

      step.count  = {1'b0, char_emit} + {1'b0, end_emit};
      step.first  = char_emit ? char_res : end_res;
      step.second = end_res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_START;
         has_chars_ff <= 1'b0;
         field_ff     <= 8'd0;
      end else if (advance) begin
         mode_ff      <= mode_in;
         has_chars_ff <= has_chars_in;
         field_ff     <= field_in;
      end
   end

endmodule

// File: rtl/csv_line_field_parser_top.sv
// Top level of the CSV line field parser: input register, parse core and a
// two-beat result buffer. Depends on csvlp_pkg and csvlp_parser.
`timescale 1ns / 1ps

// Takes one byte of a CSV line per req beat and streams field characters and
// field ends on rsp, numbering fields within the line. An item is accepted
// every cycle while results flow; each item passes the input register and the
// result buffer before it reaches rsp. An item giving two results (a byte
// or comma together with the line end) needs two rsp beats, so a run of
// those stalls req behind the single-beat rsp port and two-entry result buffer.
module csv_line_field_parser_top import csvlp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_in,
   input  logic       req_char_valid,
   input  logic       req_line_end,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_kind,
   output logic [7:0] rsp_char_out,
   output logic [7:0] rsp_field_number,
   output logic       rsp_last_field,
   output logic       rsp_last_of_item
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff;
   logic       in_cvalid_ff;
   logic       in_lend_ff;

   logic [1:0] cnt_ff, cnt_in;
   result_type slot0_ff, slot0_in;
   result_type slot1_ff, slot1_in;

   step_type   step;
   logic       pop;
   logic [1:0] cnt_after;
   logic [2:0] cnt_total;
   logic       consume;
   logic       req_take;

   csvlp_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .advance    (consume),
      .char_in    (in_char_ff),
      .char_valid (in_cvalid_ff),
      .line_end   (in_lend_ff),
      .step       (step)
   );

   assign rsp_valid = (cnt_ff != 2'd0);
   assign pop       = rsp_valid && !rsp_stall;
   assign cnt_after = cnt_ff - {1'b0, pop};
   assign cnt_total = {1'b0, cnt_after} + {1'b0, step.count};
   assign consume   = in_valid_ff && (cnt_total <= 3'd2);
   assign req_stall = in_valid_ff && !consume;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (consume) begin
         in_valid_in = 1'b0;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
      end
   end

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (pop) begin
         slot0_in = slot1_ff;
      end
      case (cnt_after)
         2'd0: begin
            if (consume) begin
               slot0_in = step.first;
               slot1_in = step.second;
            end
         end
         2'd1: begin
            if (consume) begin
               slot1_in = step.first;
            end
         end
         default: begin
         end
      endcase
      cnt_in = consume ? cnt_total[1:0] : cnt_after;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         cnt_ff      <= 2'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         cnt_ff      <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_char_ff   <= req_char_in;
         in_cvalid_ff <= req_char_valid;
         in_lend_ff   <= req_line_end;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign rsp_kind         = slot0_ff.kind;
   assign rsp_char_out     = slot0_ff.char_out;
   assign rsp_field_number = slot0_ff.field_number;
   assign rsp_last_field   = slot0_ff.last_field;
   assign rsp_last_of_item = slot0_ff.last_of_item;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'd2)
      else $error("result buffer overfilled");

   a_last_field_ends_item: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_field) |-> (rsp_last_of_item && rsp_kind == KIND_END))
      else $error("line end beat not final beat of its item");

   a_pair_fill: assert property (@(posedge clock) disable iff (reset)
      (consume && step.count == 2'd2 && cnt_after == 2'd0)
      |=> (cnt_ff == 2'd2 && !slot0_ff.last_of_item && slot1_ff.last_of_item))
      else $error("two-beat item not buffered in order");

endmodule
